[hdl/uca_pkg.sv]
// ----------------------------------------------------------------------------
// uca_pkg - shared types and constants of the uid cascade assembler
// Result codes, link status codes, the classified item passed from the
// front end to the back end, and the result record.
// ----------------------------------------------------------------------------
package uca_pkg;

  localparam int unsigned MAX_LEVELS  = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CASCADE_TAG    = 8'h88;
  localparam int unsigned MORE_BIT      = 2;
  localparam logic [2:0] ANTICOLL_BYTES = 3'd5;
  localparam logic [3:0] UID_MAX        = 4'd12;
  localparam logic [2:0] APPEND_SHORT   = 3'd3;
  localparam logic [2:0] APPEND_FULL    = 3'd4;
  localparam logic [7:0] SEL_CL2        = 8'h95;
  localparam logic [7:0] SEL_CL3        = 8'h97;
  localparam logic [1:0] LEVEL_MAX      = 2'(MAX_LEVELS);
  localparam logic [1:0] LEVEL_ONE      = 2'd1;
  localparam logic [1:0] LEVEL_TWO      = 2'd2;

  // link status codes of the reader
  localparam logic [2:0] LINK_OK        = 3'd0;
  localparam logic [2:0] LINK_TIMEOUT   = 3'd1;
  localparam logic [2:0] LINK_CRC       = 3'd3;
  localparam logic [2:0] LINK_COLLISION = 3'd4;

  typedef enum logic [2:0] {
    RES_NEXT       = 3'd0,
    RES_DONE       = 3'd1,
    RES_TIMEOUT    = 3'd2,
    RES_NO_CARD    = 3'd3,
    RES_CHECK_ERR  = 3'd4,
    RES_COLLISION  = 3'd5,
    RES_NOT_ACTIVE = 3'd6
  } res_code_e;

  // one cascade outcome after classification
  typedef struct packed {
    logic       start;
    logic       ok;
    res_code_e  err_code;
    logic       short_uid;   // cascade tag seen, three bytes appended
    logic       more;
    logic [7:0] ack;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
  } cls_t;

  typedef struct packed {
    res_code_e  result_code;
    logic [7:0] next_select_code;
    logic [3:0] uid_total;
    logic [7:0] ack_out;
    logic [2:0] append_count;
    logic [7:0] uid_out0;
    logic [7:0] uid_out1;
    logic [7:0] uid_out2;
    logic [7:0] uid_out3;
  } res_t;

  function automatic res_code_e map_status(input logic [2:0] status);
    res_code_e code;
    case (status)
      LINK_TIMEOUT:   code = RES_TIMEOUT;
      LINK_CRC:       code = RES_CHECK_ERR;
      LINK_COLLISION: code = RES_COLLISION;
      default:        code = RES_NO_CARD;
    endcase
    return code;
  endfunction

endpackage

[hdl/uca_front.sv]
// ----------------------------------------------------------------------------
// uca_front - classification of one cascade outcome
// Checks link statuses, counts and the check byte, strips the cascade tag
// and lines up the bytes to append. Holds no state of the read.
// ----------------------------------------------------------------------------
module uca_front (
  input  logic          start_req_i,
  input  logic [2:0]    anticoll_status_i,
  input  logic [2:0]    anticoll_count_i,
  input  logic [7:0]    uid_in0_i,
  input  logic [7:0]    uid_in1_i,
  input  logic [7:0]    uid_in2_i,
  input  logic [7:0]    uid_in3_i,
  input  logic [7:0]    check_in_i,
  input  logic [2:0]    select_status_i,
  input  logic [2:0]    select_count_i,
  input  logic [7:0]    ack_in_i,
  output uca_pkg::cls_t cls_o
);
  import uca_pkg::*;

  logic [7:0] bcc;
  logic       tag;

  assign bcc = uid_in0_i ^ uid_in1_i ^ uid_in2_i ^ uid_in3_i;
  assign tag = (uid_in0_i == CASCADE_TAG);

  always_comb begin
    cls_o           = '0;
    cls_o.start     = start_req_i;
    cls_o.ok        = 1'b0;
    cls_o.err_code  = RES_NO_CARD;
    cls_o.short_uid = tag;
    cls_o.more      = ack_in_i[MORE_BIT];
    cls_o.ack       = ack_in_i;

    // tests in priority order: anticollision reply, check byte, select reply
    if (anticoll_status_i != LINK_OK) begin
      cls_o.err_code = map_status(anticoll_status_i);
    end else if (anticoll_count_i != ANTICOLL_BYTES) begin
      cls_o.err_code = RES_NO_CARD;
    end else if (bcc != check_in_i) begin
      cls_o.err_code = RES_CHECK_ERR;
    end else if (select_status_i != LINK_OK) begin
      cls_o.err_code = map_status(select_status_i);
    end else if (select_count_i == 3'd0) begin
      cls_o.err_code = RES_NO_CARD;
    end else begin
      cls_o.ok = 1'b1;
    end

    if (tag) begin
      cls_o.byte0 = uid_in1_i;
      cls_o.byte1 = uid_in2_i;
      cls_o.byte2 = uid_in3_i;
      cls_o.byte3 = 8'd0;
    end else begin
      cls_o.byte0 = uid_in0_i;
      cls_o.byte1 = uid_in1_i;
      cls_o.byte2 = uid_in2_i;
      cls_o.byte3 = uid_in3_i;
    end
  end

endmodule

[hdl/uca_queue.sv]
// ----------------------------------------------------------------------------
// uca_queue - short queue of classified items
// Decouples the front end from the back end so that either side may stall.
// ----------------------------------------------------------------------------
module uca_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  uca_pkg::cls_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output uca_pkg::cls_t pop_data_o
);
  import uca_pkg::*;

  cls_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hdl/uca_back.sv]
// ----------------------------------------------------------------------------
// uca_back - read state and result register
// Tracks the read in progress, cascade level and UID length, and builds
// one result per classified item into a registered output stage.
// ----------------------------------------------------------------------------
module uca_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_valid_i,
  input  uca_pkg::cls_t item_i,
  output logic          item_pop_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output uca_pkg::res_t res_o
);
  import uca_pkg::*;

  logic       active_q, active_d;
  logic [1:0] level_q, level_d;
  logic [3:0] len_q, len_d;
  logic       res_valid_q;
  res_t       res_q, res_d;

  logic       act_eff;
  logic [1:0] lvl_eff;
  logic [3:0] len_eff;
  logic [2:0] n_app;
  logic [4:0] len_sum;
  logic [1:0] lvl_inc;

  assign item_pop_o  = item_valid_i && (!res_valid_q || res_ready_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign act_eff = item_i.start || active_q;
  assign lvl_eff = item_i.start ? LEVEL_ONE : level_q;
  assign len_eff = item_i.start ? 4'd0 : len_q;
  assign n_app   = item_i.short_uid ? APPEND_SHORT : APPEND_FULL;
  assign len_sum = {1'b0, len_eff} + {2'b00, n_app};
  assign lvl_inc = lvl_eff + 2'd1;

  always_comb begin
    active_d = act_eff;
    level_d  = lvl_eff;
    len_d    = len_eff;
    res_d    = '0;
    if (!act_eff) begin
      res_d.result_code = RES_NOT_ACTIVE;
      res_d.uid_total   = len_eff;
    end else if (!item_i.ok) begin
      active_d          = 1'b0;
      level_d           = 2'd0;
      res_d.result_code = item_i.err_code;
      res_d.uid_total   = len_eff;
    end else begin
      len_d              = (len_sum > {1'b0, UID_MAX}) ? UID_MAX : len_sum[3:0];
      res_d.uid_total    = len_d;
      res_d.ack_out      = item_i.ack;
      res_d.append_count = n_app;
      res_d.uid_out0     = item_i.byte0;
      res_d.uid_out1     = item_i.byte1;
      res_d.uid_out2     = item_i.byte2;
      res_d.uid_out3     = item_i.byte3;
      if (item_i.more && (lvl_eff < LEVEL_MAX)) begin
        level_d                = lvl_inc;
        res_d.result_code      = RES_NEXT;
        res_d.next_select_code = (lvl_inc == LEVEL_TWO) ? SEL_CL2 : SEL_CL3;
      end else begin
        active_d          = 1'b0;
        level_d           = 2'd0;
        res_d.result_code = RES_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      level_q     <= 2'd0;
      len_q       <= 4'd0;
      res_valid_q <= 1'b0;
    end else begin
      if (item_pop_o) begin
        active_q    <= active_d;
        level_q     <= level_d;
        len_q       <= len_d;
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

[hdl/uid_cascade_assembler.sv]
// ----------------------------------------------------------------------------
// uid_cascade_assembler - ISO 14443A cascade UID assembly
// Checks one cascade level outcome per beat and appends its UID bytes.
//
//   channel   | direction | tdata / tuser
//   s_axis_*  | in        | cascade outcome / start_req
//   m_axis_*  | out       | appended bytes and totals / result_code
//
// One beat accepted per cycle while s_axis_tready is high; the classified
// beat is written to the queue at the accepting edge, then its result to the
// result register. s_axis_tready falls only when the two-entry queue is full,
// which happens when m_axis_tready has been low for a while.
// Reset clears the read state (no read in progress, level 0, length 0).
// ----------------------------------------------------------------------------
module uid_cascade_assembler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] anticoll_status, [5:3] anticoll_count, [13:6] uid_in0,
  // [21:14] uid_in1, [29:22] uid_in2, [37:30] uid_in3, [45:38] check_in,
  // [48:46] select_status, [51:49] select_count, [59:52] ack_in
  input  logic [63:0] s_axis_tdata,
  // [0] start_req
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] next_select_code, [11:8] uid_total, [19:12] ack_out,
  // [22:20] append_count, [30:23] uid_out0, [38:31] uid_out1,
  // [46:39] uid_out2, [54:47] uid_out3
  output logic [55:0] m_axis_tdata,
  // [2:0] result_code
  output logic [2:0]  m_axis_tuser
);
  import uca_pkg::*;

  cls_t cls, q_data;
  res_t res;
  logic q_full, q_valid, q_pop;

  uca_front u_front (
    .start_req_i      (s_axis_tuser[0]),
    .anticoll_status_i(s_axis_tdata[2:0]),
    .anticoll_count_i (s_axis_tdata[5:3]),
    .uid_in0_i        (s_axis_tdata[13:6]),
    .uid_in1_i        (s_axis_tdata[21:14]),
    .uid_in2_i        (s_axis_tdata[29:22]),
    .uid_in3_i        (s_axis_tdata[37:30]),
    .check_in_i       (s_axis_tdata[45:38]),
    .select_status_i  (s_axis_tdata[48:46]),
    .select_count_i   (s_axis_tdata[51:49]),
    .ack_in_i         (s_axis_tdata[59:52]),
    .cls_o            (cls)
  );

  uca_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s_axis_tvalid),
    .push_data_i(cls),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_data)
  );

  uca_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(q_valid),
    .item_i      (q_data),
    .item_pop_o  (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign s_axis_tready = !q_full;
  assign m_axis_tuser  = res.result_code;
  assign m_axis_tdata  = {1'b0, res.uid_out3, res.uid_out2, res.uid_out1, res.uid_out0,
                          res.append_count, res.ack_out, res.uid_total,
                          res.next_select_code};

endmodule
